### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

### design/ljpe_pkg.sv
// Shared constants for the Lennard-Jones pair energy pipeline.
package ljpe_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int XW = 42;
  localparam logic [XW-1:0] X_CAP = XW'(1) << 41;

  localparam int WRAP_STEPS = 34;
  localparam int WRAP_LAT = WRAP_STEPS + 3;
  localparam int DIV_LAT = XW + 2;

  localparam logic [47:0] E_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] E_MIN = 48'h8000_0000_0000;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;
  localparam logic [1:0] REG_CUTOFF = 2'd3;

  localparam logic [62:0] CUTOFF_RST = 63'd618475290624;

endpackage

### design/ljpe_wrap.sv
// Periodic image wrap of one coordinate difference and its square.
module ljpe_wrap import ljpe_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [30:0] box_i,
  output logic [63:0] sq_o
);

  localparam int NB = WRAP_STEPS;

  logic signed [32:0] d;
  logic signed [34:0] num;
  logic [33:0]        nabs;

  logic [31:0] rem_q  [0:NB];
  logic [32:0] d_q    [0:NB];
  logic        neg_q  [0:NB];
  logic [31:0] den_q  [0:NB];
  logic [33:0] nabs_q [0:NB-1];

  logic [31:0]        rm;
  logic [31:0]        r;
  logic signed [33:0] dw;
  logic [32:0]        dsel;
  logic [31:0]        mag_d;
  logic [31:0]        mag_q;
  logic [63:0]        sq_q;

  assign d    = $signed({a_i[31], a_i}) - $signed({b_i[31], b_i});
  assign num  = $signed({d[32], d, 1'b0}) + $signed({4'b0, box_i});
  assign nabs = num[34] ? 34'(-num) : num[33:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      d_q[0]    <= d;
      neg_q[0]  <= num[34];
      den_q[0]  <= {box_i, 1'b0};
      nabs_q[0] <= nabs;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [32:0] t;
    logic        ge;
    assign t  = {rem_q[k], nabs_q[k][33]};
    assign ge = t >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 32'(t - {1'b0, den_q[k]}) : t[31:0];
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        den_q[k+1] <= den_q[k];
      end
    end
    if (k + 1 < NB) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nabs_q[k+1] <= {nabs_q[k][32:0], 1'b0};
        end
      end
    end
  end

  assign rm    = rem_q[NB];
  assign r     = (neg_q[NB] && rm != '0) ? den_q[NB] - rm : rm;
  assign dw    = $signed({2'b0, r}) - $signed({3'b0, den_q[NB][31:1]});
  assign dsel  = (den_q[NB] == '0) ? d_q[NB] : dw[33:1];
  assign mag_d = dsel[32] ? 32'(-dsel) : dsel[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      sq_q  <= mag_q * mag_q;
    end
  end

  assign sq_o = sq_q;

endmodule

### design/ljpe_div.sv
// Pipelined restoring divider for (sigma/r)^2, one quotient bit per stage.
module ljpe_div import ljpe_pkg::*; #(
  parameter int NUM_W = 80
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [63:0]      den_i,
  output logic [XW-1:0]    quot_o
);

  localparam int QW = XW;

  logic [63:0]   rem_q [0:QW];
  logic [63:0]   den_q [0:QW];
  logic [QW-1:0] low_q [0:QW-1];
  logic [QW-1:0] quo_q [0:QW];
  logic          ovf_q [0:QW];
  logic [63:0]   rem0;
  logic [QW-1:0] x_q;

  assign rem0 = 64'(num_i[NUM_W-1:QW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      den_q[0] <= den_i;
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= rem0 >= den_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [64:0] t;
    logic        ge;
    assign t  = {rem_q[k], low_q[k][QW-1]};
    assign ge = t >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 64'(t - {1'b0, den_q[k]}) : t[63:0];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
    if (k + 1 < QW) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q[k+1] <= {low_q[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= (ovf_q[QW] || quo_q[QW] > X_CAP) ? X_CAP : quo_q[QW];
    end
  end

  assign quot_o = x_q;

endmodule

### design/lennard_jones_pair_energy_top.sv
// Top level of the Lennard-Jones 12-6 pair energy pipeline.
//
//   channel  direction  width  content
//   s_t*     in         248    one atom pair per transfer
//   m_t*     out        48+2   pair energy and flags per transfer
//   APB      in/out     64     box lengths and squared cutoff
//
// One pair per cycle while the output is not stalled; the path holds the 34 step
// image wrap and the 42 step quotient pipeline. Reset clears valid bits and loads
// register defaults. A stall on the output freezes every stage at once.
`include "assert_macros.svh"

module lennard_jones_pair_energy_top import ljpe_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, sigma_value,
  // epsilon_value
  input  logic [247:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pair_energy
  output logic [47:0]  m_tdata,
  // pair_used, energy_saturated
  output logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int NUM_W = 48 + 2 * COORD_FRAC_BITS;
  localparam int PL = 9;

  logic [30:0] box_x_q, box_y_q, box_z_q;
  logic [62:0] cut_q;

  logic adv;

  logic [63:0] sqx, sqy, sqz;
  logic        wv_q   [0:WRAP_LAT-1];
  logic [47:0] ws2_q  [0:WRAP_LAT-1];
  logic [31:0] weps_q [0:WRAP_LAT-1];

  logic        rv_q;
  logic [63:0] r2_q;
  logic [47:0] rs2_q;
  logic [31:0] reps_q;
  logic [65:0] r2_sum;
  logic        used_d;

  logic        dv_q   [0:DIV_LAT-1];
  logic        du_q   [0:DIV_LAT-1];
  logic [31:0] deps_q [0:DIV_LAT-1];
  logic [XW-1:0] x;

  logic        pv_q [0:PL-1];
  logic        pu_q [0:PL-1];
  logic [31:0] peps_q [0:6];

  logic [XW-1:0] x1_q, x2x_q;
  logic [41:0]   m1ll_q, m1hl_q, m1hh_q;
  logic [83:0]   xx;
  logic [51:0]   x2_q;
  logic [46:0]   m2p0_q, m2p1_q, m2p2_q, m2p3_q;
  logic [93:0]   x3;
  logic [56:0]   u_q, u3_q, u4_q;
  logic          satu_q [0:5];
  logic [57:0]   m3ll_q;
  logic [56:0]   m3hl_q;
  logic [55:0]   m3hh_q;
  logic [113:0]  uu;
  logic [81:0]   u2_q;
  logic [81:0]   w_q;
  logic          neg_q [0:2];
  logic [59:0]   m4e0_q, m4e1_q;
  logic [57:0]   m4e2_q;
  logic [113:0]  pe;
  logic [79:0]   mag_q;

  logic          out_v_q;
  logic [47:0]   energy_q;
  logic          used_q, sat_q;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= '0;
      box_y_q <= '0;
      box_z_q <= '0;
      cut_q   <= CUTOFF_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_BOX_X:  box_x_q <= pwdata[30:0];
        REG_BOX_Y:  box_y_q <= pwdata[30:0];
        REG_BOX_Z:  box_z_q <= pwdata[30:0];
        REG_CUTOFF: cut_q   <= pwdata[62:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BOX_X:  prdata = 64'(box_x_q);
      REG_BOX_Y:  prdata = 64'(box_y_q);
      REG_BOX_Z:  prdata = 64'(box_z_q);
      REG_CUTOFF: prdata = 64'(cut_q);
      default:    prdata = '0;
    endcase
  end

  // global advance
  assign adv      = !out_v_q || m_tready;
  assign s_tready = adv;

  ljpe_wrap u_wrap_x (
    .clk_i, .en_i(adv), .a_i(s_tdata[31:0]), .b_i(s_tdata[127:96]),
    .box_i(box_x_q), .sq_o(sqx)
  );
  ljpe_wrap u_wrap_y (
    .clk_i, .en_i(adv), .a_i(s_tdata[63:32]), .b_i(s_tdata[159:128]),
    .box_i(box_y_q), .sq_o(sqy)
  );
  ljpe_wrap u_wrap_z (
    .clk_i, .en_i(adv), .a_i(s_tdata[95:64]), .b_i(s_tdata[191:160]),
    .box_i(box_z_q), .sq_o(sqz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WRAP_LAT; i++) wv_q[i] <= 1'b0;
    end else if (adv) begin
      wv_q[0] <= s_tvalid;
      for (int i = 1; i < WRAP_LAT; i++) wv_q[i] <= wv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ws2_q[0]  <= s_tdata[215:192] * s_tdata[215:192];
      weps_q[0] <= s_tdata[247:216];
      for (int i = 1; i < WRAP_LAT; i++) begin
        ws2_q[i]  <= ws2_q[i-1];
        weps_q[i] <= weps_q[i-1];
      end
    end
  end

  // squared distance
  assign r2_sum = {2'b0, sqx} + {2'b0, sqy} + {2'b0, sqz};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (adv) begin
      rv_q <= wv_q[WRAP_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q   <= (r2_sum[65:64] != 2'b00) ? '1 : r2_sum[63:0];
      rs2_q  <= ws2_q[WRAP_LAT-1];
      reps_q <= weps_q[WRAP_LAT-1];
    end
  end

  assign used_d = (r2_q <= {1'b0, cut_q}) && (r2_q != '0) && (rs2_q != '0) &&
                  (reps_q != '0);

  ljpe_div #(.NUM_W(NUM_W)) u_div (
    .clk_i, .en_i(adv),
    .num_i({rs2_q, (2 * COORD_FRAC_BITS)'(0)}),
    .den_i(r2_q),
    .quot_o(x)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) dv_q[i] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= rv_q;
      for (int i = 1; i < DIV_LAT; i++) dv_q[i] <= dv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      du_q[0]   <= used_d;
      deps_q[0] <= reps_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        du_q[i]   <= du_q[i-1];
        deps_q[i] <= deps_q[i-1];
      end
    end
  end

  // power chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PL; i++) pv_q[i] <= 1'b0;
    end else if (adv) begin
      pv_q[0] <= dv_q[DIV_LAT-1];
      for (int i = 1; i < PL; i++) pv_q[i] <= pv_q[i-1];
    end
  end

  assign xx = {m1hh_q, 42'd0} + 84'({m1hl_q, 22'd0}) + 84'(m1ll_q);
  assign x3 = 94'(m2p0_q) + 94'({m2p1_q, 21'd0}) + 94'({m2p2_q, 26'd0}) +
              {m2p3_q, 47'd0};
  assign uu = {m3hh_q, 58'd0} + 114'({m3hl_q, 30'd0}) + 114'(m3ll_q);
  assign pe = 114'(m4e0_q) + 114'({m4e1_q, 28'd0}) + {m4e2_q, 56'd0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pu_q[0]   <= du_q[DIV_LAT-1];
      peps_q[0] <= deps_q[DIV_LAT-1];
      for (int i = 1; i < PL; i++) pu_q[i] <= pu_q[i-1];
      for (int i = 1; i < 7; i++) peps_q[i] <= peps_q[i-1];

      x1_q   <= x;
      m1ll_q <= x[20:0] * x[20:0];
      m1hl_q <= x[20:0] * x[41:21];
      m1hh_q <= x[41:21] * x[41:21];

      x2x_q <= x1_q;
      x2_q  <= xx[83:32];

      m2p0_q <= x2_q[25:0] * x2x_q[20:0];
      m2p1_q <= x2_q[25:0] * x2x_q[41:21];
      m2p2_q <= x2_q[51:26] * x2x_q[20:0];
      m2p3_q <= x2_q[51:26] * x2x_q[41:21];

      u_q       <= x3[88:32];
      satu_q[0] <= x3[93:89] != '0;

      m3ll_q    <= u_q[28:0] * u_q[28:0];
      m3hl_q    <= u_q[28:0] * u_q[56:29];
      m3hh_q    <= u_q[56:29] * u_q[56:29];
      u3_q      <= u_q;
      for (int i = 1; i < 6; i++) satu_q[i] <= satu_q[i-1];

      u2_q <= uu[113:32];
      u4_q <= u3_q;

      neg_q[0] <= u2_q < 82'(u4_q);
      w_q      <= (u2_q < 82'(u4_q)) ? 82'(u4_q) - u2_q : u2_q - 82'(u4_q);

      m4e0_q   <= w_q[27:0] * peps_q[6];
      m4e1_q   <= w_q[55:28] * peps_q[6];
      m4e2_q   <= w_q[81:56] * peps_q[6];
      neg_q[1] <= neg_q[0];

      mag_q    <= pe[113:34];
      neg_q[2] <= neg_q[1];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= pv_q[PL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!pu_q[PL-1]) begin
        energy_q <= '0;
        used_q   <= 1'b0;
        sat_q    <= 1'b0;
      end else if (satu_q[5]) begin
        energy_q <= E_MAX;
        used_q   <= 1'b1;
        sat_q    <= 1'b1;
      end else if (!neg_q[2]) begin
        used_q   <= 1'b1;
        sat_q    <= mag_q > 80'(E_MAX);
        energy_q <= (mag_q > 80'(E_MAX)) ? E_MAX : mag_q[47:0];
      end else begin
        used_q   <= 1'b1;
        sat_q    <= mag_q > 80'(E_MIN);
        energy_q <= (mag_q > 80'(E_MIN)) ? E_MIN : 48'(-mag_q[47:0]);
      end
    end
  end

  assign m_tvalid = out_v_q;
  assign m_tdata  = energy_q;
  assign m_tuser  = {sat_q, used_q};

  `ASSERT_IMPLIES(a_sat_used, clk_i, rst_ni, m_tvalid && m_tuser[1], m_tuser[0], "saturated but unused")
  `ASSERT_IMPLIES(a_unused_zero, clk_i, rst_ni, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tuser[1], "unused pair not zero")
  `ASSERT_IMPLIES(a_sat_value, clk_i, rst_ni, m_tvalid && m_tuser[1], m_tdata == E_MAX || m_tdata == E_MIN, "saturated value off range")

endmodule

### tb/sv/tb_lennard_jones_pair_energy_top.sv
// Testbench for the Lennard-Jones pair energy pipeline: directed and random pairs, scoreboard check.
`timescale 1ns / 1ps

module tb_lennard_jones_pair_energy_top import ljpe_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [31:0] ANGSTROM = 32'h0001_0000;

  typedef struct packed {
    logic [47:0] energy;
    logic        used;
    logic        saturated;
  } pair_result_t;

  class lj_score_board;
    logic [30:0]  box_x, box_y, box_z;
    logic [62:0]  cutoff_sq;
    pair_result_t pending[$];
    int           errors;

    function new();
      box_x = '0;
      box_y = '0;
      box_z = '0;
      cutoff_sq = CUTOFF_RST;
      errors = 0;
    endfunction

    function logic [63:0] image_square(logic [31:0] a, logic [31:0] b, logic [30:0] box);
      longint d, bb, num, den, n;
      logic [63:0] mag;
      d = longint'($signed(a)) - longint'($signed(b));
      if (box != 0) begin
        bb = longint'({33'd0, box});
        num = 2 * d + bb;
        den = 2 * bb;
        n = num / den;
        if (num % den != 0 && num < 0) n = n - 1;
        d = d - n * bb;
      end
      mag = d < 0 ? -d : d;
      return mag * mag;
    endfunction

    function logic [63:0] q32_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] t;
      t = ({64'd0, a} * {64'd0, b}) >> 32;
      return t[127:64] != 0 ? '1 : t[63:0];
    endfunction

    function void note_pair(logic [247:0] d);
      logic [65:0]  acc;
      logic [63:0]  r2, x, x2, u;
      logic [23:0]  sig;
      logic [31:0]  eps;
      logic [127:0] q, u2;
      logic signed [129:0] w;
      logic [191:0] mag;
      pair_result_t r;
      sig = d[215:192];
      eps = d[247:216];
      r = '0;
      acc = {2'b0, image_square(d[31:0], d[127:96], box_x)}
          + {2'b0, image_square(d[63:32], d[159:128], box_y)}
          + {2'b0, image_square(d[95:64], d[191:160], box_z)};
      r2 = acc[65:64] != 0 ? '1 : acc[63:0];
      if (!(r2 > {1'b0, cutoff_sq} || r2 == 0 || sig == 0 || eps == 0)) begin
        r.used = 1'b1;
        q = ({80'd0, {24'd0, sig} * {24'd0, sig}} << 32) / {64'd0, r2};
        x = q > {86'd0, X_CAP} ? {22'd0, X_CAP} : q[63:0];
        x2 = q32_product(x, x);
        u = q32_product(x2, x);
        if (u >= (64'd1 << 57)) begin
          r.energy = E_MAX;
          r.saturated = 1'b1;
        end else begin
          u2 = ({64'd0, u} * {64'd0, u}) >> 32;
          w = $signed({2'b0, u2}) - $signed({66'd0, u});
          mag = ({62'd0, (w < 0 ? -w : w)} * {160'd0, eps}) >> 34;
          if (w >= 0) begin
            if (mag > {144'd0, E_MAX}) begin
              r.energy = E_MAX;
              r.saturated = 1'b1;
            end else r.energy = mag[47:0];
          end else begin
            if (mag > {144'd0, E_MIN}) begin
              r.energy = E_MIN;
              r.saturated = 1'b1;
            end else r.energy = -mag[47:0];
          end
        end
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [47:0] energy, logic [1:0] flags);
      pair_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transfer energy=%h flags=%b", energy, flags));
        return;
      end
      e = pending.pop_front();
      if (energy !== e.energy) report($sformatf("energy %h, want %h", energy, e.energy));
      if (flags[0] !== e.used) report($sformatf("pair_used %b, want %b", flags[0], e.used));
      if (flags[1] !== e.saturated)
        report($sformatf("energy_saturated %b, want %b", flags[1], e.saturated));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [247:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  lj_score_board board = new();
  bit  steady = 1'b0;
  int  cycles = 0;

  lennard_jones_pair_energy_top dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) m_tready <= steady || ($urandom_range(0, 99) >= 14);

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) board.note_pair(s_tdata);
    if (rst_ni && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BOX_X:  board.box_x = value[30:0];
      REG_BOX_Y:  board.box_y = value[30:0];
      REG_BOX_Z:  board.box_z = value[30:0];
      REG_CUTOFF: board.cutoff_sq = value[62:0];
      default:    ;
    endcase
  endtask

  task automatic set_geometry(logic [63:0] bx, logic [63:0] by, logic [63:0] bz,
                              logic [63:0] cut);
    wait (board.pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    write_reg(REG_CUTOFF, cut);
  endtask

  task automatic send_pair(logic [247:0] d);
    while (!steady && $urandom_range(0, 99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic logic [247:0] pack_pair(logic [31:0] fx, logic [31:0] fy,
      logic [31:0] fz, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
      logic [23:0] sig, logic [31:0] eps);
    return {eps, sig, sz, sy, sx, fz, fy, fx};
  endfunction

  task automatic send_random(int count);
    logic [31:0] f[3], s[3];
    logic [23:0] sig;
    logic [31:0] eps;
    for (int k = 0; k < count; k++) begin
      for (int a = 0; a < 3; a++) begin
        f[a] = $urandom();
        s[a] = f[a] - ($urandom_range(0, 24 * ANGSTROM) - 12 * ANGSTROM);
      end
      sig = $urandom_range(0, 9) == 0 ? 24'($urandom_range(0, 1) * 24'hFF_FFFF)
                                      : 24'($urandom_range(1, 6 * ANGSTROM));
      eps = $urandom_range(0, 19) == 0 ? 32'd0 : $urandom();
      if ($urandom_range(0, 7) == 0) begin
        for (int a = 0; a < 3; a++) s[a] = $urandom();
        sig = 24'($urandom());
      end
      send_pair(pack_pair(f[0], f[1], f[2], s[0], s[1], s[2], sig, eps));
    end
    s_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero distance, beyond cutoff, zero sigma, zero epsilon
    send_pair(pack_pair(5, 6, 7, 5, 6, 7, 24'(3 * ANGSTROM), 32'h1000_0000));
    send_pair(pack_pair(0, 0, 0, 13 * ANGSTROM, 0, 0, 24'(3 * ANGSTROM), 32'h1000_0000));
    send_pair(pack_pair(0, 0, 0, 4 * ANGSTROM, 0, 0, 24'd0, 32'h1000_0000));
    send_pair(pack_pair(0, 0, 0, 4 * ANGSTROM, 0, 0, 24'(3 * ANGSTROM), 32'd0));
    // very close pair saturates
    send_pair(pack_pair(0, 0, 0, 1, 0, 0, 24'hFF_FFFF, 32'hFFFF_FFFF));
    send_pair(pack_pair(0, 0, 0, ANGSTROM, 0, 0, 24'(3 * ANGSTROM), 32'h0100_0000));
    // attractive well and exact cutoff boundary
    send_pair(pack_pair(0, 0, 0, 4 * ANGSTROM, 0, 0, 24'(3 * ANGSTROM), 32'hFFFF_FFFF));
    send_pair(pack_pair(0, 0, 0, 12 * ANGSTROM, 0, 0, 24'(3 * ANGSTROM), 32'hFFFF_FFFF));
    send_pair(pack_pair(-2 * ANGSTROM, 3 * ANGSTROM, -ANGSTROM, 0, 0, 0,
                        24'h03_6666, 32'h0400_0000));
    // coordinate extremes
    send_pair(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                        24'hFF_FFFF, 32'hFFFF_FFFF));
    send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0001, 32'h8000_0000, 32'h8000_0000,
                        24'd1, 32'd1));
    send_random(140);

    set_geometry(64'(20 * ANGSTROM), 64'(20 * ANGSTROM), 64'(20 * ANGSTROM),
                 64'(CUTOFF_RST));
    steady = 1'b1;
    send_random(200);
    steady = 1'b0;

    set_geometry(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(pack_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                        24'hFF_FFFF, 32'hFFFF_FFFF));
    send_random(150);

    set_geometry(64'd0, 64'd0, 64'd0, 64'd0);
    send_random(100);

    set_geometry({32'h8000_0000, 7 * ANGSTROM}, 64'(13 * ANGSTROM), 64'(30 * ANGSTROM),
                 64'h8000_0000_0000_0000 | (64'd25 << 32));
    send_random(350);

    wait (board.pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ljpe_pkg.sv
design/ljpe_wrap.sv
design/ljpe_div.sv
design/lennard_jones_pair_energy_top.sv
tb/sv/tb_lennard_jones_pair_energy_top.sv
